// ===== rtl/core/sorted_timer_event_queue_unit_assert.svh =====
// assertion macros shared by the checker of the timer event queue
// no dependencies; include by bare file name
`ifndef SORTED_TIMER_EVENT_QUEUE_UNIT_ASSERT_SVH
`define SORTED_TIMER_EVENT_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define STQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define STQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/stq_pkg.sv =====
// shared types, constants and the wrap-safe time compare of the timer event queue
// no dependencies
package stq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    localparam logic [15:0] RESET_DEFAULT_DELAY = 16'd1000;

    typedef struct packed {
        logic [31:0] tstamp;
        logic [7:0]  gate;
        logic        level;
    } slot_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic [31:0] target;
        logic [7:0]  gate;
        logic        level;
    } cell_cmd_t;

    // a strictly later than b, modulo 2^32
    function automatic logic later_than(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

endpackage

// ===== rtl/core/stq_cell.sv =====
// one slot of the sorted chain: holds an event and shifts with its neighbours
// depends on stq_pkg
module stq_cell (
    input  logic              aclk,
    input  stq_pkg::cell_cmd_t cmd,
    input  logic              in_use,
    input  logic              at_end,
    input  logic              left_later,
    input  stq_pkg::slot_t    left_slot,
    input  stq_pkg::slot_t    right_slot,
    output stq_pkg::slot_t    slot,
    output logic              later
);

    stq_pkg::slot_t slot_reg;
    stq_pkg::slot_t slot_next;

    assign later = in_use && stq_pkg::later_than(slot_reg.tstamp, cmd.target);
    assign slot  = slot_reg;

    always_comb begin
        slot_next = slot_reg;
        unique case (cmd.op)
            stq_pkg::OP_HOLD: begin
                slot_next = slot_reg;
            end
            stq_pkg::OP_INSERT: begin
                // everything later than the new word moves one place right
                if (left_later) begin
                    slot_next = left_slot;
                end else if (later || at_end) begin
                    slot_next.tstamp = cmd.target;
                    slot_next.gate   = cmd.gate;
                    slot_next.level  = cmd.level;
                end
            end
            stq_pkg::OP_POP: begin
                slot_next = right_slot;
            end
            default: begin
                slot_next = slot_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

endmodule

// ===== rtl/core/sorted_timer_event_queue_unit.sv =====
// channel  | signals                                              | word
// ---------+------------------------------------------------------+--------------------------
// s_       | s_valid s_ready                                      | kind gate_index level delay
// m_       | m_valid m_ready                                      | gate level dropped last
// cfg_     | cfg_wr_en cfg_wr_data                                | default delay, no stall
//
// a schedule: accept, then one insert step across the cell chain
// a tick: accept and advance time, then pop the due events one by one, up to 16; none if nothing is due
// a refused schedule passes a drop step; any result word waits while the previous one is held by m_ready low
// reset clears time, occupancy and control; slot contents stay undefined, no clearing pass
// top level of the timer event queue; depends on stq_pkg and stq_cell
module sorted_timer_event_queue_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_gate_index,
    input  logic        s_event_level,
    input  logic [15:0] s_delay,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_fired_gate,
    output logic        m_fired_level,
    output logic        m_dropped,
    output logic        m_last
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_INSERT = 4'b0010,
        ST_POP    = 4'b0100,
        ST_DROP   = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [15:0]                  dflt_delay_reg, dflt_delay_next;
    logic [31:0]                  time_now_reg, time_now_next;
    logic [stq_pkg::OCC_W-1:0]    occ_reg, occ_next;
    logic [stq_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [31:0]                  target_reg, target_next;
    logic [7:0]                   pend_gate_reg, pend_gate_next;
    logic                         pend_level_reg, pend_level_next;
    logic                         m_valid_reg, m_valid_next;
    logic [7:0]                   m_gate_reg, m_gate_next;
    logic                         m_level_reg, m_level_next;
    logic                         m_dropped_reg, m_dropped_next;
    logic                         m_last_reg, m_last_next;

    stq_pkg::cell_cmd_t           cmd;
    stq_pkg::slot_t               slots [stq_pkg::QUEUE_DEPTH];
    logic [stq_pkg::QUEUE_DEPTH-1:0] later_vec;

    logic in_acc, out_free, queue_full, head_due, next_due, pop_go, emit_last;
    logic [15:0] delay_eff;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign queue_full = (occ_reg == stq_pkg::OCC_W'(stq_pkg::QUEUE_DEPTH));
    assign delay_eff  = (s_delay == 16'd0) ? dflt_delay_reg : s_delay;

    assign head_due = (occ_reg != '0)
                   && !stq_pkg::later_than(slots[0].tstamp, time_now_reg);
    assign next_due = (occ_reg > stq_pkg::OCC_W'(1))
                   && !stq_pkg::later_than(slots[1].tstamp, time_now_reg);
    assign pop_go    = (state_reg == ST_POP) && head_due && out_free;
    assign emit_last = (cnt_reg == stq_pkg::CNT_W'(stq_pkg::MAX_RESULTS - 1)) || !next_due;

    always_comb begin
        cmd.target = target_reg;
        cmd.gate   = pend_gate_reg;
        cmd.level  = pend_level_reg;
        if (state_reg == ST_INSERT) begin
            cmd.op = stq_pkg::OP_INSERT;
        end else if (pop_go) begin
            cmd.op = stq_pkg::OP_POP;
        end else begin
            cmd.op = stq_pkg::OP_HOLD;
        end
    end

    for (genvar i = 0; i < stq_pkg::QUEUE_DEPTH; i++) begin : g_cell
        localparam int LI = (i == 0) ? 0 : i - 1;
        localparam int RI = (i == stq_pkg::QUEUE_DEPTH - 1) ? i : i + 1;

        stq_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .in_use     (occ_reg > stq_pkg::OCC_W'(i)),
            .at_end     (occ_reg == stq_pkg::OCC_W'(i)),
            .left_later ((i != 0) && later_vec[LI]),
            .left_slot  (slots[LI]),
            .right_slot (slots[RI]),
            .slot       (slots[i]),
            .later      (later_vec[i])
        );
    end

    always_comb begin
        state_next      = state_reg;
        dflt_delay_next = cfg_wr_en ? cfg_wr_data : dflt_delay_reg;
        time_now_next   = time_now_reg;
        occ_next        = occ_reg;
        cnt_next        = cnt_reg;
        target_next     = target_reg;
        pend_gate_next  = pend_gate_reg;
        pend_level_next = pend_level_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_gate_next     = m_gate_reg;
        m_level_next    = m_level_reg;
        m_dropped_next  = m_dropped_reg;
        m_last_next     = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    pend_gate_next  = s_gate_index;
                    pend_level_next = s_event_level;
                    target_next     = time_now_reg + {16'd0, delay_eff};
                    if (!s_kind) begin
                        time_now_next = time_now_reg + 32'd1;
                        cnt_next      = '0;
                        state_next    = ST_POP;
                    end else if (queue_full) begin
                        state_next = ST_DROP;
                    end else begin
                        state_next = ST_INSERT;
                    end
                end
            end
            ST_INSERT: begin
                occ_next   = occ_reg + stq_pkg::OCC_W'(1);
                state_next = ST_IDLE;
            end
            ST_POP: begin
                if (!head_due) begin
                    state_next = ST_IDLE;
                end else if (pop_go) begin
                    m_valid_next   = 1'b1;
                    m_gate_next    = slots[0].gate;
                    m_level_next   = slots[0].level;
                    m_dropped_next = 1'b0;
                    m_last_next    = emit_last;
                    occ_next       = occ_reg - stq_pkg::OCC_W'(1);
                    cnt_next       = cnt_reg + stq_pkg::CNT_W'(1);
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DROP: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_gate_next    = pend_gate_reg;
                    m_level_next   = pend_level_reg;
                    m_dropped_next = 1'b1;
                    m_last_next    = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            dflt_delay_reg <= stq_pkg::RESET_DEFAULT_DELAY;
            time_now_reg   <= '0;
            occ_reg        <= '0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            dflt_delay_reg <= dflt_delay_next;
            time_now_reg   <= time_now_next;
            occ_reg        <= occ_next;
            cnt_reg        <= cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        target_reg     <= target_next;
        pend_gate_reg  <= pend_gate_next;
        pend_level_reg <= pend_level_next;
        m_gate_reg     <= m_gate_next;
        m_level_reg    <= m_level_next;
        m_dropped_reg  <= m_dropped_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_fired_gate  = m_gate_reg;
    assign m_fired_level = m_level_reg;
    assign m_dropped     = m_dropped_reg;
    assign m_last        = m_last_reg;

endmodule

// ===== rtl/core/stq_checker.sv =====
// port-level checks of the timer event queue, bound to the top level
// depends on sorted_timer_event_queue_unit_assert.svh
`include "sorted_timer_event_queue_unit_assert.svh"

module stq_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_fired_gate,
    input logic       m_fired_level,
    input logic       m_dropped,
    input logic       m_last
);

    // a stalled result word keeps its contents
    `STQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_fired_gate) && $stable(m_fired_level)
        && $stable(m_dropped) && $stable(m_last), "result word changed while stalled")

    // a refused schedule is always a word of its own
    `STQ_ASSERT_IMP(a_drop_last, aclk, aresetn, m_valid && m_dropped,
        m_last, "dropped word without last")

    // every accepted word takes the block out of idle, which closes the input
    `STQ_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready,
        !s_ready, "input ready straight after an accept")

    // while a burst of fired events is unfinished no new word is taken
    `STQ_ASSERT_IMP(a_burst_closed, aclk, aresetn, m_valid && !m_last,
        !s_ready, "input ready in the middle of a burst")

endmodule

bind sorted_timer_event_queue_unit stq_checker u_stq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_fired_gate  (m_fired_gate),
    .m_fired_level (m_fired_level),
    .m_dropped     (m_dropped),
    .m_last        (m_last)
);

// ===== tb/tb_top.sv =====
// self-checking testbench for the sorted timer event queue: directed words, then random phases
// depends on stq_pkg and sorted_timer_event_queue_unit; the queue model below predicts each result
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit KIND_TICK     = 1'b0;
    localparam bit KIND_SCHEDULE = 1'b1;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PRINT_LIMIT   = 50;

    typedef struct {
        bit        kind;
        bit [7:0]  gate;
        bit        level;
        bit [15:0] delay;
    } sched_word_t;

    typedef struct {
        bit [7:0] gate;
        bit       level;
        bit       dropped;
        bit       last;
    } fired_word_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [15:0] cfg_wr_data   = 16'd0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic        s_kind        = 1'b0;
    logic [7:0]  s_gate_index  = 8'd0;
    logic        s_event_level = 1'b0;
    logic [15:0] s_delay       = 16'd0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [7:0]  m_fired_gate;
    logic        m_fired_level;
    logic        m_dropped;
    logic        m_last;

    sched_word_t pending_words[$];
    fired_word_t expected_fires[$];

    // queue model state
    bit [31:0] clock_now = 32'd0;
    bit [15:0] dflt_delay = stq_pkg::RESET_DEFAULT_DELAY;
    bit [31:0] slot_due[stq_pkg::QUEUE_DEPTH];
    bit [7:0]  slot_gate[stq_pkg::QUEUE_DEPTH];
    bit        slot_level[stq_pkg::QUEUE_DEPTH];
    int        slots_used = 0;

    int error_count   = 0;
    int cycle_count   = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    int holdoff_asked = 0;
    int holdoff_done  = 0;
    int hold_left     = 0;
    int pattern_age   = 0;
    bit [7:0] ready_pattern = 8'hFF;

    sorted_timer_event_queue_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_gate_index  (s_gate_index),
        .s_event_level (s_event_level),
        .s_delay       (s_delay),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_fired_gate  (m_fired_gate),
        .m_fired_level (m_fired_level),
        .m_dropped     (m_dropped),
        .m_last        (m_last)
    );

    always #1 aclk = ~aclk;

    // wrap-safe: a lies strictly after b
    function automatic bit is_after(input bit [31:0] a, input bit [31:0] b);
        return $signed(a - b) > 0;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // apply one accepted word to the model and queue the words it must produce
    task automatic queue_model_step(input bit kind, input bit [7:0] gate, input bit level,
                                    input bit [15:0] delay);
        bit [31:0]   due;
        int          pos;
        int          fired;
        fired_word_t w;
        if (kind == KIND_SCHEDULE) begin
            if (slots_used >= stq_pkg::QUEUE_DEPTH) begin
                w.gate = gate;
                w.level = level;
                w.dropped = 1'b1;
                w.last = 1'b1;
                expected_fires.push_back(w);
            end else begin
                due = clock_now + ((delay == 16'd0) ? {16'd0, dflt_delay} : {16'd0, delay});
                pos = slots_used;
                // equal times stay ahead of the newcomer
                while (pos > 0 && is_after(slot_due[pos-1], due)) begin
                    slot_due[pos]   = slot_due[pos-1];
                    slot_gate[pos]  = slot_gate[pos-1];
                    slot_level[pos] = slot_level[pos-1];
                    pos--;
                end
                slot_due[pos]   = due;
                slot_gate[pos]  = gate;
                slot_level[pos] = level;
                slots_used++;
            end
        end else begin
            clock_now = clock_now + 32'd1;
            fired = 0;
            while (fired < stq_pkg::MAX_RESULTS && slots_used > 0 &&
                   !is_after(slot_due[0], clock_now)) begin
                w.gate = slot_gate[0];
                w.level = slot_level[0];
                w.dropped = 1'b0;
                for (int i = 1; i < slots_used; i++) begin
                    slot_due[i-1]   = slot_due[i];
                    slot_gate[i-1]  = slot_gate[i];
                    slot_level[i-1] = slot_level[i];
                end
                slots_used--;
                fired++;
                w.last = (fired == stq_pkg::MAX_RESULTS) || (slots_used == 0) ||
                         is_after(slot_due[0], clock_now);
                expected_fires.push_back(w);
            end
        end
    endtask

    // sender: bursts of words with random gaps between them
    always @(posedge aclk) begin
        sched_word_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                w = pending_words.pop_front();
                s_valid       <= 1'b1;
                s_kind        <= w.kind;
                s_gate_index  <= w.gate;
                s_event_level <= w.level;
                s_delay       <= w.delay;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: rotating stall pattern, changed now and then, plus long hold-offs on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (holdoff_asked != holdoff_done) begin
                holdoff_done = holdoff_asked;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (pattern_age == 0) begin
                    case ($urandom_range(0, 3))
                        0: ready_pattern = 8'hFF;
                        1: ready_pattern = 8'hAA;
                        2: ready_pattern = 8'h11;
                        default: ready_pattern = 8'($urandom()) | 8'h01;
                    endcase
                    pattern_age = $urandom_range(20, 80);
                end else begin
                    pattern_age--;
                end
                m_ready <= ready_pattern[0];
                ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
            end
        end
    end

    // monitor: predict on input handshakes, check on output handshakes
    always @(posedge aclk) begin
        fired_word_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                queue_model_step(s_kind, s_gate_index, s_event_level, s_delay);
            end
            if (m_valid && m_ready) begin
                if (expected_fires.size() == 0) begin
                    report_mismatch($sformatf("unexpected word gate %0h level %0b dropped %0b last %0b",
                                              m_fired_gate, m_fired_level, m_dropped, m_last));
                end else begin
                    want = expected_fires.pop_front();
                    if (m_fired_gate !== want.gate || m_fired_level !== want.level ||
                        m_dropped !== want.dropped || m_last !== want.last) begin
                        report_mismatch($sformatf(
                            "got gate %0h level %0b dropped %0b last %0b, want %0h %0b %0b %0b",
                            m_fired_gate, m_fired_level, m_dropped, m_last,
                            want.gate, want.level, want.dropped, want.last));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timed out with %0d words outstanding", expected_fires.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic add_word(input bit kind, input bit [7:0] gate, input bit level,
                            input bit [15:0] delay);
        sched_word_t w;
        w.kind = kind;
        w.gate = gate;
        w.level = level;
        w.delay = delay;
        pending_words.push_back(w);
    endtask

    // tick with junk in the ignored fields
    task automatic add_tick();
        add_word(KIND_TICK, 8'($urandom()), 1'($urandom()), 16'($urandom()));
    endtask

    function automatic bit [15:0] pick_delay();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            return 16'($urandom_range(13, 65535));  // far future, rarely fires
        end
        if (roll < ((dflt_delay <= 16'd40) ? 25 : 4)) begin
            return 16'd0;
        end
        return 16'($urandom_range(1, 12));
    endfunction

    // a few schedules followed by enough ticks to let some of them fire
    task automatic add_sequence(output int made);
        int n_sched;
        int n_tick;
        n_sched = $urandom_range(1, 5);
        n_tick = $urandom_range(1, 10);
        for (int i = 0; i < n_sched; i++) begin
            add_word(KIND_SCHEDULE, 8'($urandom()), 1'($urandom()), pick_delay());
        end
        repeat (n_tick) add_tick();
        made = n_sched + n_tick;
    endtask

    // schedule from twelve up to two past capacity with one due time, then tick until it is reached
    task automatic add_flood(output int made);
        bit [15:0] dd;
        int        due;
        int        n_sched;
        int        n_tick;
        dd = (dflt_delay <= 16'd8) ? 16'd0 : 16'($urandom_range(1, 4));
        due = (dd == 16'd0) ? int'(dflt_delay) : int'(dd);
        n_sched = $urandom_range(stq_pkg::QUEUE_DEPTH - 4, stq_pkg::QUEUE_DEPTH + 2);
        n_tick = ((due == 0) ? 1 : due) + $urandom_range(0, 2);
        for (int i = 0; i < n_sched; i++) begin
            add_word(KIND_SCHEDULE, 8'($urandom()), 1'($urandom()), dd);
        end
        repeat (n_tick) add_tick();
        made = n_sched + n_tick;
    endtask

    task automatic add_noise(output int made);
        bit kind;
        made = $urandom_range(1, 6);
        for (int i = 0; i < made; i++) begin
            kind = 1'($urandom());
            add_word(kind, 8'($urandom()), 1'($urandom()),
                     ($urandom_range(0, 29) == 0) ? 16'($urandom()) : pick_delay());
        end
    endtask

    task automatic fill_phase(input int quota, input bit flood_first);
        int made;
        int n;
        int roll;
        made = 0;
        if (flood_first) begin
            add_flood(n);
            made += n;
        end
        while (made < quota) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                add_sequence(n);
            end else if (roll < 75) begin
                add_flood(n);
            end else begin
                add_noise(n);
            end
            made += n;
        end
    endtask

    task automatic wait_until_drained();
        do begin
            @(posedge aclk);
        end while (pending_words.size() != 0 || s_valid || expected_fires.size() != 0);
        // a schedule or an empty tick may still be in flight with nothing owed
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_default_delay(input bit [15:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        dflt_delay = value;
    endtask

    initial begin
        bit [15:0] delay_settings[4];
        delay_settings[0] = 16'd1;
        delay_settings[1] = 16'hFFFF;
        delay_settings[2] = 16'd0;
        delay_settings[3] = 16'($urandom_range(2, 40));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // sixteen with one due time: fire in arrival order on a single tick
        for (int i = 0; i < stq_pkg::QUEUE_DEPTH; i++) begin
            add_word(KIND_SCHEDULE, 8'(8'h40 + i), i[0], 16'd3);
        end
        add_word(KIND_SCHEDULE, 8'hFF, 1'b1, 16'hFFFF);  // queue full, refused
        repeat (3) add_word(KIND_TICK, 8'hFF, 1'b1, 16'hFFFF);
        add_word(KIND_SCHEDULE, 8'h00, 1'b0, 16'h0000);  // reset default delay
        add_word(KIND_SCHEDULE, 8'hFF, 1'b1, 16'hFFFF);
        add_word(KIND_SCHEDULE, 8'h5A, 1'b0, 16'd1);
        add_word(KIND_TICK, 8'h00, 1'b0, 16'h0000);
        add_word(KIND_TICK, 8'h00, 1'b0, 16'h0000);       // nothing due
        wait_until_drained();

        foreach (delay_settings[p]) begin
            write_default_delay(delay_settings[p]);
            // long receiver stall while a flood backs up the block
            if (p == 0) begin
                holdoff_asked++;
            end
            fill_phase(45, p == 0);
            wait_until_drained();
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/stq_pkg.sv
rtl/core/stq_cell.sv
rtl/core/sorted_timer_event_queue_unit.sv
rtl/core/stq_checker.sv
tb/tb_top.sv
